// ===== design/kclt_pkg.sv =====
// Shared types, codes and command/status bundles of the keyed circular list table.
package kclt_pkg;

	localparam int KEY_W = 16;
	localparam int PAY_W = 16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_LIST   = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [2:0] {
		RES_OK,
		RES_MISS,
		RES_FULL,
		RES_HIT,
		RES_ENTRY
	} res_kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_TAIL,
		S_SEARCH,
		S_HIT,
		S_LIST,
		S_OK,
		S_MISS,
		S_FULL
	} state_t;

	typedef struct packed {
		logic      in_ready;
		logic      track_head;
		logic      scan_adv;
		logic      ins_write;
		logic      walk_adv;
		logic      tail_write;
		logic      set_head;
		logic      unlink_prev;
		logic      free_cur;
		logic      drop_all;
		logic      save_link;
		logic      emit;
		res_kind_t kind;
		logic      emit_last;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		op_t  in_op;
		op_t  op;
		logic empty;
		logic slot_free;
		logic scan_end;
		logic key_hit;
		logic next_is_head;
		logic cur_is_head;
		logic single;
		logic out_free;
	} sts_t;

endpackage

// ===== design/kclt_ifs.sv =====
// Request and response channel interfaces of the keyed circular list table.
interface kclt_req_if
	import kclt_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [1:0]       op;
	logic [KEY_W-1:0] key;
	logic [PAY_W-1:0] payload;

	modport source (output valid, op, key, payload, input ready);
	modport sink   (input valid, op, key, payload, output ready);
endinterface

interface kclt_rsp_if
	import kclt_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic             found;
	logic [KEY_W-1:0] out_key;
	logic [PAY_W-1:0] out_payload;
	logic             last;

	modport source (output valid, status, found, out_key, out_payload, last, input ready);
	modport sink   (input valid, status, found, out_key, out_payload, last, output ready);
endinterface

// ===== design/kclt_ctrl.sv =====
// Controller state machine: sequences scans, chain walks and result emission.
module kclt_ctrl
	import kclt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (sts.in_valid) begin
					unique case (sts.in_op)
						OP_INSERT: state_d = S_SCAN;
						OP_REMOVE,
						OP_LOOKUP: state_d = sts.empty ? S_MISS : S_SEARCH;
						OP_LIST:   state_d = sts.empty ? S_MISS : S_LIST;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				priority if (sts.slot_free) begin
					state_d = sts.empty ? S_OK : S_TAIL;
				end else if (sts.scan_end) begin
					state_d = S_FULL;
				end
			end
			S_TAIL: begin
				if (sts.next_is_head) begin
					state_d = (sts.op == OP_REMOVE) ? S_IDLE : S_OK;
				end
			end
			S_SEARCH: begin
				priority if (sts.key_hit) begin
					state_d = S_HIT;
				end else if (sts.next_is_head) begin
					state_d = S_MISS;
				end
			end
			S_HIT: begin
				if (sts.out_free) begin
					if (sts.op == OP_REMOVE && sts.cur_is_head && !sts.single) begin
						state_d = S_TAIL;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_LIST: begin
				if (sts.out_free && sts.next_is_head) begin
					state_d = S_IDLE;
				end
			end
			S_OK, S_MISS, S_FULL: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.kind = RES_OK;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready   = 1'b1;
				cmd.track_head = 1'b1;
			end
			S_SCAN: begin
				cmd.ins_write = sts.slot_free;
				cmd.scan_adv  = !sts.slot_free;
			end
			S_TAIL: begin
				if (sts.next_is_head) begin
					cmd.tail_write = 1'b1;
					cmd.set_head   = (sts.op == OP_REMOVE);
				end else begin
					cmd.walk_adv = 1'b1;
				end
			end
			S_SEARCH: begin
				cmd.walk_adv = !sts.key_hit && !sts.next_is_head;
			end
			S_HIT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.kind      = RES_HIT;
					cmd.emit_last = 1'b1;
					if (sts.op == OP_REMOVE) begin
						cmd.free_cur = 1'b1;
						priority if (sts.single) begin
							cmd.drop_all = 1'b1;
						end else if (sts.cur_is_head) begin
							// head leaves: remember successor, walk on to the tail
							cmd.save_link = 1'b1;
							cmd.walk_adv  = 1'b1;
						end else begin
							cmd.unlink_prev = 1'b1;
						end
					end
				end
			end
			S_LIST: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.kind      = RES_ENTRY;
					cmd.emit_last = sts.next_is_head;
					cmd.walk_adv  = !sts.next_is_head;
				end
			end
			S_OK: begin
				cmd.emit      = sts.out_free;
				cmd.kind      = RES_OK;
				cmd.emit_last = 1'b1;
			end
			S_MISS: begin
				cmd.emit      = sts.out_free;
				cmd.kind      = RES_MISS;
				cmd.emit_last = 1'b1;
			end
			S_FULL: begin
				cmd.emit      = sts.out_free;
				cmd.kind      = RES_FULL;
				cmd.emit_last = 1'b1;
			end
			default: cmd.in_ready = 1'b0;
		endcase
	end

endmodule

// ===== design/kclt_dpath.sv =====
// Datapath: slot memories, used bits, chain pointers and the result register.
module kclt_dpath
	import kclt_pkg::*;
#(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	kclt_req_if.sink          req,
	kclt_rsp_if.source        rsp,
	input  cmd_t              cmd,
	output sts_t              sts
);

	localparam int IW = $clog2(CAPACITY);
	localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

	logic [KW+PAY_W-1:0] kp_mem [CAPACITY];
	logic [IW-1:0]       nx_mem [CAPACITY];

	logic [KW+PAY_W-1:0] rd_kp_q;
	logic [IW-1:0]       rd_next_q;

	logic [CAPACITY-1:0] used_q;
	logic [IW-1:0]       head_q;
	logic                empty_q;
	logic [IW-1:0]       cur_q;
	logic [IW-1:0]       cur_d;
	logic [IW-1:0]       prev_q;
	logic [IW-1:0]       scan_q;
	logic [IW-1:0]       link_q;

	op_t                 op_q;
	logic [KW-1:0]       key_q;
	logic [PAY_W-1:0]    pay_q;

	logic                out_valid_q;
	logic [1:0]          status_q;
	logic                found_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [PAY_W-1:0]    out_pay_q;
	logic                last_q;

	logic                accept;
	logic                out_free;
	logic [KW-1:0]       rd_key;
	logic [PAY_W-1:0]    rd_pay;
	logic                nx_we;
	logic [IW-1:0]       nx_waddr;
	logic [IW-1:0]       nx_wdata;

	assign accept   = req.valid && cmd.in_ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign rd_key   = rd_kp_q[KW+PAY_W-1:PAY_W];
	assign rd_pay   = rd_kp_q[PAY_W-1:0];

	assign req.ready = cmd.in_ready;

	// the read port follows the slot that cur_q will point at
	always_comb begin
		priority if (cmd.track_head) begin
			cur_d = head_q;
		end else if (cmd.walk_adv) begin
			cur_d = rd_next_q;
		end else begin
			cur_d = cur_q;
		end
	end

	always_comb begin
		nx_we    = 1'b1;
		nx_waddr = scan_q;
		nx_wdata = empty_q ? scan_q : head_q;
		priority if (cmd.ins_write) begin
			nx_waddr = scan_q;
			nx_wdata = empty_q ? scan_q : head_q;
		end else if (cmd.tail_write) begin
			nx_waddr = cur_q;
			nx_wdata = link_q;
		end else if (cmd.unlink_prev) begin
			nx_waddr = prev_q;
			nx_wdata = rd_next_q;
		end else begin
			nx_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			kp_mem[scan_q] <= {key_q, pay_q};
		end
		if (nx_we) begin
			nx_mem[nx_waddr] <= nx_wdata;
		end
		rd_kp_q   <= kp_mem[cur_d];
		rd_next_q <= nx_mem[cur_d];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(req.op);
			key_q <= req.key[KW-1:0];
			pay_q <= req.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			head_q  <= '0;
			empty_q <= 1'b1;
			cur_q   <= '0;
			prev_q  <= '0;
			scan_q  <= '0;
			link_q  <= '0;
		end else begin
			cur_q <= cur_d;
			if (cmd.walk_adv) begin
				prev_q <= cur_q;
			end
			if (accept) begin
				scan_q <= '0;
			end else if (cmd.scan_adv) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.ins_write) begin
				used_q[scan_q] <= 1'b1;
				link_q         <= scan_q;
				if (empty_q) begin
					head_q  <= scan_q;
					empty_q <= 1'b0;
				end
			end
			if (cmd.free_cur) begin
				used_q[cur_q] <= 1'b0;
			end
			if (cmd.save_link) begin
				link_q <= rd_next_q;
			end
			if (cmd.tail_write && cmd.set_head) begin
				head_q <= link_q;
			end
			if (cmd.drop_all) begin
				head_q  <= '0;
				empty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			last_q <= cmd.emit_last;
			unique case (cmd.kind)
				RES_HIT, RES_ENTRY: begin
					status_q  <= ST_OK;
					found_q   <= (cmd.kind == RES_HIT);
					out_key_q <= KEY_W'(rd_key);
					out_pay_q <= rd_pay;
				end
				RES_MISS: begin
					status_q  <= ST_MISS;
					found_q   <= 1'b0;
					out_key_q <= '0;
					out_pay_q <= '0;
				end
				RES_FULL: begin
					status_q  <= ST_FULL;
					found_q   <= 1'b0;
					out_key_q <= '0;
					out_pay_q <= '0;
				end
				default: begin
					status_q  <= ST_OK;
					found_q   <= 1'b0;
					out_key_q <= '0;
					out_pay_q <= '0;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.found       = found_q;
	assign rsp.out_key     = out_key_q;
	assign rsp.out_payload = out_pay_q;
	assign rsp.last        = last_q;

	always_comb begin
		sts.in_valid     = req.valid;
		sts.in_op        = op_t'(req.op);
		sts.op           = op_q;
		sts.empty        = empty_q;
		sts.slot_free    = !used_q[scan_q];
		sts.scan_end     = (scan_q == IW'(CAPACITY - 1));
		sts.key_hit      = (rd_key == key_q);
		sts.next_is_head = (rd_next_q == head_q);
		sts.cur_is_head  = (cur_q == head_q);
		sts.single       = (rd_next_q == cur_q);
		sts.out_free     = out_free;
	end

endmodule

// ===== design/keyed_circular_list_table_top.sv =====
// Top level of the keyed circular list table: controller plus datapath.
//
// Keeps a circular singly linked list of up to CAPACITY entries (key, payload).
// Request channel req carries op, key and payload; one item is taken at a time.
// Response channel rsp carries status, found, out_key, out_payload and last;
// last marks the final result of an item.
// Insert: scans the used bits one slot per cycle for the lowest free slot, then
// walks the chain one slot per cycle to the tail (not if the list was empty)
// and links the new entry; one result follows, FULL if no slot is free.
// Remove and lookup walk from the head one slot per cycle until the first key
// match; removing the head adds a walk to the tail to close the ring.
// List emits one entry per cycle from the head while rsp accepts.
// A result sits in an output register; the next item is taken while it waits.
// When rsp stalls, a pending result or list walk holds and resumes when the register frees.
// Reset clears all used bits and empties the list; slot contents stay unknown.
module keyed_circular_list_table_top
	import kclt_pkg::*;
#(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	kclt_req_if.sink   req,
	kclt_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	kclt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	kclt_dpath #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// ===== design/kclt_checker.sv =====
// Port-level checks of the keyed circular list table, bound to the top level.
module kclt_checker
	import kclt_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [1:0]       rsp_status,
	input logic             rsp_found,
	input logic [KEY_W-1:0] rsp_out_key,
	input logic             rsp_last
);

	// one item at a time: ready drops right after an item is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is in progress");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_MISS ||
			rsp_status == ST_FULL))
		else $error("undefined status code");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found |-> rsp_status == ST_OK && rsp_last)
		else $error("match reported with bad status or not last");

	a_error_final: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_last && !rsp_found && rsp_out_key == '0)
		else $error("error result not final or carries data");

endmodule

bind keyed_circular_list_table_top kclt_checker u_kclt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_status  (rsp.status),
	.rsp_found   (rsp.found),
	.rsp_out_key (rsp.out_key),
	.rsp_last    (rsp.last)
);
